### hw/rtl/esp_pkg.sv
// Package for the encoder speed PID controller.
// Constants, configuration register indexes, sequencer states and divider structs.
// No dependencies.
package esp_pkg;

  localparam int unsigned DIV_W     = 30;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [DIV_W-1:0] RPM_NUM      = 30'd663540000;
  localparam int unsigned      PERIOD_SHIFT = 9;
  localparam logic [12:0]      SPEED_MAX    = 13'd7000;
  localparam logic [15:0]      INTEG_MAX    = 16'd60000;
  localparam logic [17:0]      ZERO_BLEED   = 18'd20;
  localparam logic [9:0]       KI_SCALE     = 10'd1000;
  localparam logic [7:0]       STALL_TICKS  = 8'd5;
  localparam logic [7:0]       STALL_SAT    = 8'hff;

  localparam logic [9:0] PWM_LIMIT_RST   = 10'd511;
  localparam logic [7:0] KP_DIV_RST      = 8'd3;
  localparam logic [7:0] KI_DIV_RST      = 8'd3;
  localparam logic [7:0] KD_GAIN_RST     = 8'd2;
  localparam logic [7:0] SAMPLE_TIME_RST = 8'd33;

  localparam logic [2:0] CFG_PWM_LIMIT   = 3'd0;
  localparam logic [2:0] CFG_KP_DIV      = 3'd1;
  localparam logic [2:0] CFG_KI_DIV      = 3'd2;
  localparam logic [2:0] CFG_KD_GAIN     = 3'd3;
  localparam logic [2:0] CFG_SAMPLE_TIME = 3'd4;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_AVG,
    ST_RPM,
    ST_PROP,
    ST_INTEG,
    ST_DERIV,
    ST_MUL,
    ST_EMIT
  } esp_state_e;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] nbits;
    logic [DIV_W-1:0]     dividend;
    logic [DIV_W-1:0]     divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

### hw/rtl/esp_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Runs nbits steps on a dividend of at most nbits bits. Depends on esp_pkg.
module esp_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  esp_pkg::div_req_t req_i,
  output esp_pkg::div_rsp_t rsp_o
);
  import esp_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [DIV_W-1:0]     dvs_q, dvs_d;
  logic [DIV_W:0]       trial;
  logic [DIV_W+1:0]     diff;
  logic                 ge;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};
  assign ge    = ~diff[DIV_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.nbits;
      rem_d  = '0;
      quo_d  = req_i.dividend << (DIV_CNT_W'(DIV_W) - req_i.nbits);
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], ge};
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

endmodule

### hw/rtl/encoder_speed_pid_controller.sv
// Encoder speed measurement and PID speed controller, top level.
// Depends on esp_pkg and esp_div.
//
// Input stream: tuser carries the kind of item (0 encoder edge, 1 control tick).
// An edge item updates the last timestamp and, unless timer_fault is set, the
// stored edge period, and clears the stall count; it gives no result. A tick
// item averages the period history into a speed in rpm (zero when stalled)
// and runs the PID loop; it gives one result item with the duty, the measured
// speed and the stall flag. All divisions of a tick run one after another on
// one shared bit-serial divider at one quotient bit per cycle: average
// (16+clog2(AVG_TAPS) bits), rpm (30), proportional (16), integral (24),
// derivative gain (8), then a multiply step and an output step. The rpm
// division is skipped when the average is zero, which keeps the last speed,
// and the average and rpm divisions both when the motor is stalled.
// The input is not ready while a tick is in work.
// The result sits in an output register; the next item is accepted while it
// waits. A tick that completes while the previous result is still not taken
// holds in its last step until the output register frees up.
// Reset loads the register defaults and clears all history; no clearing pass.
// Configuration writes act at once; the user makes them while idle; not checked.
module encoder_speed_pid_controller #(
  parameter int unsigned AVG_TAPS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [15:0] timestamp, [16] timer_fault, [32:17] target_speed, [39:33] zero
  input  logic [39:0] s_axis_tdata_i,
  // [0] op
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [9:0] pwm_duty, [22:10] measured_speed, [23] stalled
  output logic [23:0] m_axis_tdata_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_data_i
);
  import esp_pkg::*;

  localparam int unsigned SUM_W = 16 + $clog2(AVG_TAPS);

  esp_state_e state_q, state_d;

  logic [9:0] pwm_limit_q;
  logic [7:0] kp_div_q, ki_div_q, kd_gain_q, sample_time_q;

  logic [15:0]      last_stamp_q, edge_period_q;
  logic [15:0]      hist_q [AVG_TAPS];
  logic [SUM_W-1:0] sum_q;
  logic [12:0]      speed_q;
  logic [7:0]       twe_q;
  logic [15:0]      integ_q;
  logic [15:0]      prev_q;

  logic [15:0]        target_q;
  logic               stall_q;
  logic [15:0]        avg_q;
  logic signed [16:0] pterm_q;
  logic [13:0]        iterm_q;
  logic [7:0]         kdt_q;
  logic signed [25:0] dterm_q;

  logic        m_valid_q;
  logic [23:0] m_data_q;

  logic        div_launched_q;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  logic        accept, is_div_state, out_free, load_out;
  logic        stall_now;
  logic [15:0] in_stamp, in_target, period;
  logic        in_fault;
  logic [7:0]  kp_nz, ki_nz, t_nz;
  logic [17:0] ki_k;
  logic [23:0] ti;
  logic signed [15:0] e_s;
  logic [15:0]        e_abs;
  logic signed [17:0] integ_raw;
  logic [15:0]        integ_new;
  logic signed [16:0] ediff;
  logic signed [27:0] ysum;
  logic [9:0]         y_clamp;

  assign in_stamp  = s_axis_tdata_i[15:0];
  assign in_fault  = s_axis_tdata_i[16];
  assign in_target = s_axis_tdata_i[32:17];

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign stall_now = twe_q >= STALL_TICKS;
  assign period    = in_stamp - last_stamp_q - {15'd0, (in_stamp <= last_stamp_q)};
  assign out_free  = !m_valid_q || m_axis_tready_i;

  assign kp_nz = (kp_div_q == 8'd0) ? 8'd1 : kp_div_q;
  assign ki_nz = (ki_div_q == 8'd0) ? 8'd1 : ki_div_q;
  assign t_nz  = (sample_time_q == 8'd0) ? 8'd1 : sample_time_q;
  assign ki_k  = 18'(ki_nz) * 18'(KI_SCALE);
  assign ti    = 24'(t_nz) * 24'(integ_q);

  assign e_s       = $signed(target_q - {3'd0, speed_q});
  assign e_abs     = e_s[15] ? (~e_s + 16'd1) : e_s;
  assign integ_raw = $signed({2'b00, integ_q}) + 18'(e_s)
                   - ((target_q == 16'd0) ? $signed(ZERO_BLEED) : 18'sd0);
  assign integ_new = integ_raw[17] ? 16'd0 :
                     (integ_raw > $signed({2'b00, INTEG_MAX})) ? INTEG_MAX :
                     integ_raw[15:0];
  assign ediff     = 17'(e_s) - 17'($signed(prev_q));

  assign ysum    = 28'(pterm_q) + $signed({14'd0, iterm_q}) + 28'(dterm_q);
  assign y_clamp = ysum[27] ? 10'd0 :
                   (ysum > $signed({18'd0, pwm_limit_q})) ? pwm_limit_q : ysum[9:0];

  assign is_div_state = (state_q == ST_AVG) || (state_q == ST_RPM) || (state_q == ST_PROP)
                     || (state_q == ST_INTEG) || (state_q == ST_DERIV);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && s_axis_tuser_i == OP_TICK) begin
          state_d = stall_now ? ST_PROP : ST_AVG;
        end
      end
      ST_AVG: begin
        if (div_rsp.done) begin
          state_d = (div_rsp.quot == '0) ? ST_PROP : ST_RPM;
        end
      end
      ST_RPM: begin
        if (div_rsp.done) state_d = ST_PROP;
      end
      ST_PROP: begin
        if (div_rsp.done) state_d = ST_INTEG;
      end
      ST_INTEG: begin
        if (div_rsp.done) state_d = ST_DERIV;
      end
      ST_DERIV: begin
        if (div_rsp.done) state_d = ST_MUL;
      end
      ST_MUL: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready_o  = (state_q == ST_IDLE);
    load_out         = (state_q == ST_EMIT) && out_free;
    div_req.start    = is_div_state && !div_launched_q;
    div_req.nbits    = '0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    case (state_q)
      ST_AVG: begin
        div_req.nbits    = DIV_CNT_W'(SUM_W);
        div_req.dividend = DIV_W'(sum_q);
        div_req.divisor  = DIV_W'(AVG_TAPS);
      end
      ST_RPM: begin
        div_req.nbits    = DIV_CNT_W'(DIV_W);
        div_req.dividend = RPM_NUM;
        div_req.divisor  = DIV_W'({avg_q, {PERIOD_SHIFT{1'b0}}});
      end
      ST_PROP: begin
        div_req.nbits    = DIV_CNT_W'(16);
        div_req.dividend = DIV_W'(e_abs);
        div_req.divisor  = DIV_W'(kp_nz);
      end
      ST_INTEG: begin
        div_req.nbits    = DIV_CNT_W'(24);
        div_req.dividend = DIV_W'(ti);
        div_req.divisor  = DIV_W'(ki_k);
      end
      ST_DERIV: begin
        div_req.nbits    = DIV_CNT_W'(8);
        div_req.dividend = DIV_W'(kd_gain_q);
        div_req.divisor  = DIV_W'(t_nz);
      end
      default: ;
    endcase
  end

  esp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      div_launched_q <= 1'b0;
      m_valid_q      <= 1'b0;
      pwm_limit_q    <= PWM_LIMIT_RST;
      kp_div_q       <= KP_DIV_RST;
      ki_div_q       <= KI_DIV_RST;
      kd_gain_q      <= KD_GAIN_RST;
      sample_time_q  <= SAMPLE_TIME_RST;
      last_stamp_q   <= '0;
      edge_period_q  <= '0;
      for (int i = 0; i < AVG_TAPS; i++) hist_q[i] <= '0;
      sum_q          <= '0;
      speed_q        <= '0;
      twe_q          <= '0;
      integ_q        <= '0;
      prev_q         <= '0;
    end else begin
      state_q <= state_d;

      if (div_req.start) begin
        div_launched_q <= 1'b1;
      end else if (div_rsp.done) begin
        div_launched_q <= 1'b0;
      end

      if (load_out) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PWM_LIMIT:   pwm_limit_q   <= cfg_data_i;
          CFG_KP_DIV:      kp_div_q      <= cfg_data_i[7:0];
          CFG_KI_DIV:      ki_div_q      <= cfg_data_i[7:0];
          CFG_KD_GAIN:     kd_gain_q     <= cfg_data_i[7:0];
          CFG_SAMPLE_TIME: sample_time_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (accept && s_axis_tuser_i == OP_EDGE) begin
        if (!in_fault) edge_period_q <= period;
        last_stamp_q <= in_stamp;
        twe_q        <= '0;
      end

      if (accept && s_axis_tuser_i == OP_TICK) begin
        if (stall_now) begin
          speed_q <= '0;
        end else begin
          for (int i = AVG_TAPS - 1; i > 0; i--) hist_q[i] <= hist_q[i-1];
          hist_q[0] <= edge_period_q;
          sum_q     <= sum_q - SUM_W'(hist_q[AVG_TAPS-1]) + SUM_W'(edge_period_q);
        end
        if (twe_q != STALL_SAT) twe_q <= twe_q + 8'd1;
      end

      if (state_q == ST_RPM && div_rsp.done) begin
        speed_q <= (div_rsp.quot > DIV_W'(SPEED_MAX)) ? 13'd0 : div_rsp.quot[12:0];
      end

      if (state_q == ST_PROP && div_rsp.done) begin
        integ_q <= integ_new;
      end

      if (load_out) begin
        prev_q <= e_s;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && s_axis_tuser_i == OP_TICK) begin
      target_q <= in_target;
      stall_q  <= stall_now;
    end
    if (state_q == ST_AVG && div_rsp.done) begin
      avg_q <= div_rsp.quot[15:0];
    end
    if (state_q == ST_PROP && div_rsp.done) begin
      pterm_q <= e_s[15] ? -$signed({1'b0, div_rsp.quot[15:0]})
                         : $signed({1'b0, div_rsp.quot[15:0]});
    end
    if (state_q == ST_INTEG && div_rsp.done) begin
      iterm_q <= div_rsp.quot[13:0];
    end
    if (state_q == ST_DERIV && div_rsp.done) begin
      kdt_q <= div_rsp.quot[7:0];
    end
    if (state_q == ST_MUL) begin
      dterm_q <= 26'($signed({1'b0, kdt_q})) * 26'(ediff);
    end
    if (load_out) begin
      m_data_q <= {stall_q, speed_q, y_clamp};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef SYNTHESIS
  a_speed_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    speed_q <= SPEED_MAX)
    else $error("speed above maximum");

  a_integ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_q <= INTEG_MAX)
    else $error("integral above clamp");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> is_div_state && div_launched_q)
    else $error("divider result outside a division step");

  a_duty_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> m_data_q[9:0] <= pwm_limit_q)
    else $error("duty above limit");

  a_stall_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> !m_data_q[23] || m_data_q[22:10] == 13'd0)
    else $error("stalled result with nonzero speed");
`endif

endmodule

### tb/encoder_speed_pid_controller_test.sv
// Self-checking testbench for encoder_speed_pid_controller: edge and tick items go in on
// the input stream, and each tick's duty, speed and stall flag are checked against a
// built-in predictor. Depends on esp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module encoder_speed_pid_controller_test;
  import esp_pkg::*;

  localparam int unsigned TAPS       = 8;
  localparam int unsigned CYCLE_MAX  = 1500000;
  localparam logic [31:0] RPM_SCALE  = 32'd663540000;
  localparam int unsigned RPM_TOP    = 7000;
  localparam int          ACC_TOP    = 60000;
  localparam int          ZERO_DRAIN = 20;
  localparam logic [7:0]  STALL_AT   = 8'd5;
  localparam logic [7:0]  COUNT_TOP  = 8'hff;

  typedef struct packed {
    logic        stalled;
    logic [12:0] rpm;
    logic [9:0]  duty;
  } drive_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;
  logic        s_axis_tuser_i = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [9:0]  cfg_data_i = '0;

  encoder_speed_pid_controller #(.AVG_TAPS(TAPS)) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // predictor state
  logic [9:0]  lim_r;
  logic [7:0]  kp_r, ki_r, kd_r, ts_r;
  logic [15:0] last_stamp_r, period_r;
  logic [15:0] hist_r [TAPS];
  logic [12:0] rpm_r;
  logic [7:0]  idle_ticks_r;
  logic [15:0] integ_r, prev_err_r;

  drive_t      duty_q [$];
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned items_sent;
  bit          gaps_on;
  bit          stalls_on;
  logic [15:0] motor_stamp;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_MAX) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("** encoder_speed_pid_controller: FAILED **");
      $finish;
    end
  end

  function automatic void reset_loop();
    lim_r        = 10'd511;
    kp_r         = 8'd3;
    ki_r         = 8'd3;
    kd_r         = 8'd2;
    ts_r         = 8'd33;
    last_stamp_r = '0;
    period_r     = '0;
    for (int i = 0; i < TAPS; i++) hist_r[i] = '0;
    rpm_r        = '0;
    idle_ticks_r = '0;
    integ_r      = '0;
    prev_err_r   = '0;
  endfunction

  function automatic void step_loop(input logic op, input logic [15:0] stamp,
                                    input logic fault, input logic [15:0] target);
    logic [31:0] sum, avg, q;
    logic [15:0] diff;
    logic        stall;
    int          e, acc, kp, ki, ts, kd, prev, y;
    drive_t      r;
    if (op == OP_EDGE) begin
      if (!fault) begin
        if (stamp > last_stamp_r) period_r = stamp - last_stamp_r;
        else period_r = (16'hffff - last_stamp_r) + stamp;
      end
      last_stamp_r = stamp;
      idle_ticks_r = '0;
      return;
    end
    stall = idle_ticks_r >= STALL_AT;
    if (!stall) begin
      for (int i = TAPS - 1; i > 0; i--) hist_r[i] = hist_r[i-1];
      hist_r[0] = period_r;
      sum = '0;
      for (int i = 0; i < TAPS; i++) sum += 32'(hist_r[i]);
      avg = sum / TAPS;
      if (avg != 0) begin
        q = RPM_SCALE / (avg * 512);
        rpm_r = (q > RPM_TOP) ? 13'd0 : q[12:0];
      end
    end else begin
      rpm_r = '0;
    end
    if (idle_ticks_r < COUNT_TOP) idle_ticks_r++;

    diff = target - {3'b000, rpm_r};
    e = int'($signed(diff));
    acc = int'(integ_r) + e;
    if (target == 16'd0) acc -= ZERO_DRAIN;
    if (acc < 0) acc = 0;
    if (acc > ACC_TOP) acc = ACC_TOP;
    integ_r = acc[15:0];

    kp   = (kp_r == 0) ? 1 : int'(kp_r);
    ki   = (ki_r == 0) ? 1 : int'(ki_r);
    ts   = (ts_r == 0) ? 1 : int'(ts_r);
    kd   = int'(kd_r);
    prev = int'($signed(prev_err_r));
    y = e / kp + (ts * acc) / (1000 * ki) + (kd / ts) * (e - prev);
    if (y < 0) y = 0;
    if (y > int'(lim_r)) y = int'(lim_r);
    prev_err_r = diff;

    r.duty    = y[9:0];
    r.rpm     = rpm_r;
    r.stalled = stall;
    duty_q.push_back(r);
  endfunction

  // result checker
  always @(posedge clk_i) begin
    drive_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      if (duty_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: duty %0d speed %0d stalled %0b",
                                       got.duty, got.rpm, got.stalled);
      end else begin
        want = duty_q.pop_front();
        if (got.duty !== want.duty || got.rpm !== want.rpm || got.stalled !== want.stalled) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: duty exp %0d got %0d, speed exp %0d got %0d, stalled exp %0b got %0b",
                     want.duty, got.duty, want.rpm, got.rpm, want.stalled, got.stalled);
        end
      end
    end
  end

  // result sink with random back-pressure when stalls_on is set
  initial begin : sink
    int unsigned hold;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      hold = stalls_on ? $urandom_range(0, 6) : 0;
      if (hold > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input logic op, input logic [15:0] stamp, input logic fault,
                           input logic [15:0] target);
    int unsigned gap;
    gap = gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {7'b0, target, fault, stamp};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    step_loop(op, stamp, fault, target);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_pulse(input logic [15:0] stamp, input logic fault);
    send_item(OP_EDGE, stamp, fault, 16'($urandom()));
  endtask

  task automatic send_tick(input logic [15:0] target);
    send_item(OP_TICK, 16'($urandom()), 1'($urandom()), target);
  endtask

  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (duty_q.size() != 0) @(negedge clk_i);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [9:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    case (idx)
      CFG_PWM_LIMIT:   lim_r = value;
      CFG_KP_DIV:      kp_r  = value[7:0];
      CFG_KI_DIV:      ki_r  = value[7:0];
      CFG_KD_GAIN:     kd_r  = value[7:0];
      CFG_SAMPLE_TIME: ts_r  = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic apply_config(input logic [9:0] lim, input logic [9:0] kp,
                              input logic [9:0] ki, input logic [9:0] kd,
                              input logic [9:0] ts);
    settle();
    write_reg(CFG_PWM_LIMIT, lim);
    write_reg(CFG_KP_DIV, kp);
    write_reg(CFG_KI_DIV, ki);
    write_reg(CFG_KD_GAIN, kd);
    write_reg(CFG_SAMPLE_TIME, ts);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] pick_target();
    int unsigned k;
    k = $urandom_range(0, 19);
    if (k == 0) return 16'd0;
    if (k == 1) return 16'($urandom());
    return 16'($urandom_range(0, 7000));
  endfunction

  // motor turning at a roughly steady rate, ticks in between edges
  task automatic run_motor(input int unsigned n_ticks, input int unsigned p_lo,
                           input int unsigned p_hi);
    int unsigned n_edges;
    for (int t = 0; t < n_ticks; t++) begin
      n_edges = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 3);
      for (int k = 0; k < n_edges; k++) begin
        motor_stamp += 16'($urandom_range(p_lo, p_hi));
        send_pulse(motor_stamp, $urandom_range(0, 15) == 0);
      end
      send_tick(pick_target());
    end
  endtask

  task automatic test_directed();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
    send_tick(16'd1000);            // empty history keeps speed 0
    send_pulse(16'h0000, 1'b0);     // equal stamp gives full period
    send_tick(16'd0);               // zero target drains the integral
    send_pulse(16'hffff, 1'b0);
    send_pulse(16'h0100, 1'b0);     // timer wrap
    send_pulse(16'h0300, 1'b1);     // fault keeps the old period
    send_tick(16'hffff);            // error wraps
    send_tick(16'h8000);
    send_pulse(16'h0301, 1'b0);     // period of one
    send_tick(16'd7000);
    send_pulse(16'h03c9, 1'b0);
    send_tick(16'd5000);
    for (int i = 0; i < 7; i++) send_tick(i == 6 ? 16'd0 : 16'd3000);  // into stall
    send_pulse(16'h07b1, 1'b0);
    send_tick(16'd2000);
    settle();
  endtask

  task automatic test_config_extremes();
    apply_config(10'd1023, 10'd1, 10'd1, 10'd255, 10'd1);
    run_motor(10, 186, 600);
    apply_config(10'd0, 10'd255, 10'd255, 10'd0, 10'd255);
    run_motor(8, 600, 5000);
    apply_config(10'd1023, 10'd0, 10'd0, 10'd255, 10'd0);   // zero divisors
    run_motor(10, 186, 2000);
    apply_config(10'd1023, 10'd1023, 10'd768, 10'd512, 10'd257);
    run_motor(8, 186, 1000);
    apply_config(10'd511, 10'd3, 10'd3, 10'd2, 10'd33);
    run_motor(10, 200, 800);
  endtask

  task automatic test_stall_saturation();
    apply_config(10'($urandom()), 10'($urandom()), 10'($urandom()),
                 10'($urandom()), 10'($urandom()));
    run_motor(6, 186, 600);
    for (int i = 0; i < 262; i++) send_tick(pick_target());
    motor_stamp += 16'd300;
    send_pulse(motor_stamp, 1'b0);
    run_motor(4, 250, 350);
  endtask

  task automatic test_random();
    int unsigned kind, p_lo, p_hi;
    while (items_sent < 1800) begin
      if ($urandom_range(0, 2) == 0)
        apply_config(10'($urandom()), 10'($urandom()), 10'($urandom()),
                     10'($urandom()), 10'($urandom()));
      gaps_on   = $urandom_range(0, 3) != 0;
      stalls_on = $urandom_range(0, 3) != 0;
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        case ($urandom_range(0, 3))
          0:       begin p_lo = 1;    p_hi = 185;   end
          1:       begin p_lo = 186;  p_hi = 600;   end
          2:       begin p_lo = 600;  p_hi = 5000;  end
          default: begin p_lo = 5000; p_hi = 65535; end
        endcase
        run_motor($urandom_range(15, 40), p_lo, p_hi);
      end else if (kind < 9) begin
        for (int i = 0; i < $urandom_range(20, 50); i++)
          send_item(1'($urandom()), 16'($urandom()), 1'($urandom()), 16'($urandom()));
      end else begin
        for (int i = 0; i < $urandom_range(4, 12); i++) send_tick(pick_target());
        run_motor($urandom_range(3, 8), 186, 3000);
      end
    end
  endtask

  initial begin
    reset_loop();
    mismatches  = 0;
    cycle_cnt   = 0;
    items_sent  = 0;
    motor_stamp = 16'h07b1;
    gaps_on     = 1'b0;
    stalls_on   = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_config_extremes();
    test_stall_saturation();
    test_random();

    settle();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && duty_q.size() == 0) begin
      $display("** encoder_speed_pid_controller: PASSED **");
    end else begin
      $display("** encoder_speed_pid_controller: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/esp_pkg.sv
hw/rtl/esp_div.sv
hw/rtl/encoder_speed_pid_controller.sv
tb/encoder_speed_pid_controller_test.sv
